// ===== design/fat_chain_allocator_unit_assert.svh =====
// Assertion macros used by the checker of the FAT chain allocator.
// Plain text macros only; no other dependencies.
`ifndef FAT_CHAIN_ALLOCATOR_UNIT_ASSERT_SVH
`define FAT_CHAIN_ALLOCATOR_UNIT_ASSERT_SVH

// Next-cycle implication that is also checked while reset is applied.
`define FCA_ASSERT_NEXT_RST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("fca assertion failed");

// Next-cycle implication that is ignored while reset is applied.
`define FCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fca assertion failed");

`endif

// ===== design/fca_pkg.sv =====
// Shared types, codes and constants of the FAT chain allocator.
// No dependencies; the design modules, the checker and the testbench import this package.
`timescale 1ns / 1ps

package fca_pkg;

  // Fixed field widths.
  localparam int ENTRY_W   = 14;
  localparam int DS_W      = 13;
  localparam int LEN_W     = 25;
  localparam int IDX_OUT_W = 13;
  localparam int CNT_W     = 14;

  // Table entry codes: zero is a free block, all ones ends a chain.
  localparam logic [ENTRY_W-1:0] FAT_FREE = '0;
  localparam logic [ENTRY_W-1:0] FAT_END  = '1;

  localparam logic [LEN_W-1:0] MAX_FILE_BYTES = LEN_W'(16777216);
  localparam logic [DS_W-1:0]  DS_RESET       = DS_W'(10);

  // Defaults of the top-level parameters.
  localparam int NUM_BLOCKS_DEF  = 8192;
  localparam int BLOCK_BYTES_DEF = 4096;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_EXTEND = 2'd2,
    ACT_TRUNC  = 2'd3
  } fca_action_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_FREE = 2'd1,
    STAT_CORRUPT = 2'd2
  } fca_status_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HEAD,
    ST_SCAN,
    ST_FREE,
    ST_FREE_RD,
    ST_EXT_CHK,
    ST_EXT_RD,
    ST_EXT_END,
    ST_TRN_CHK,
    ST_TRN_RD,
    ST_TRN_CUT,
    ST_TRN_CUT_RD,
    ST_TRN_FREE,
    ST_TRN_FREE_RD,
    ST_DONE
  } fca_state_t;

  // Request beat.
  typedef struct packed {
    logic [1:0]       action;
    logic [DS_W-1:0]  head_block;
    logic [LEN_W-1:0] byte_length;
  } fca_in_t;

  // Result beat.
  typedef struct packed {
    logic [1:0]           status;
    logic [IDX_OUT_W-1:0] block_index;
    logic [CNT_W-1:0]     blocks_changed;
  } fca_out_t;

  // Configuration beat: the data start register.
  typedef logic [DS_W-1:0] fca_ds_t;

endpackage

// ===== design/fca_chan_if.sv =====
// Valid/ready channel interface used for the request, result and config ports.
// The payload type is a parameter; no package dependency.
`timescale 1ns / 1ps

interface fca_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/fat_chain_allocator_unit.sv =====
// Allocate scans table entries first-fit; free releases each chain block; extend
// follows existing links and appends new blocks; truncate follows the kept links
// and frees the rest. One request is in flight at a time; the table memory port
// sets the pace. After reset a clearing pass writes every entry free, one per
// cycle, during which no request beat is accepted.
`timescale 1ns / 1ps

module fat_chain_allocator_unit #(
  parameter int NUM_BLOCKS  = fca_pkg::NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = fca_pkg::BLOCK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  fca_chan_if.sink    in_ch,
  fca_chan_if.source  out_ch,
  fca_chan_if.sink    cfg_ch
);
  import fca_pkg::*;

  localparam int ADDR_W = $clog2(NUM_BLOCKS);

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic               res_valid;
  logic               res_ready;
  fca_out_t           res_data;

  logic               out_valid_r;
  fca_out_t           out_data_r;

  fca_in_t            in_beat;
  fca_ds_t            cfg_beat;

  assign in_beat  = in_ch.data;
  assign cfg_beat = cfg_ch.data;

  // The data start register takes a beat in any cycle.
  assign cfg_ch.ready = 1'b1;

  fca_fat_ram #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .ADDR_W     (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fca_ctrl #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES),
    .ADDR_W      (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_beat),
    .cfg_we    (cfg_ch.valid),
    .cfg_data  (cfg_beat),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Output register: a finished result waits here while the next request runs.
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

// ===== design/fca_fat_ram.sv =====
// Allocation table storage: one write port and one registered read port.
// Depends on fca_pkg for the entry width.
`timescale 1ns / 1ps

module fca_fat_ram #(
  parameter int NUM_BLOCKS = fca_pkg::NUM_BLOCKS_DEF,
  parameter int ADDR_W     = $clog2(NUM_BLOCKS)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [fca_pkg::ENTRY_W-1:0] wdata,
  input  logic                        re,
  input  logic [ADDR_W-1:0]           raddr,
  output logic [fca_pkg::ENTRY_W-1:0] rdata
);
  import fca_pkg::*;

  logic [ENTRY_W-1:0] mem [NUM_BLOCKS];
  logic [ENTRY_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port. A read of the entry written in the same cycle returns the new
  // value. The data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata_r <= wdata;
      end else begin
        rdata_r <= mem[raddr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/fca_ctrl.sv =====
// Request sequencer: walks and scans the allocation table one entry at a time.
// Depends on fca_pkg; drives the table through the fca_fat_ram ports.
`timescale 1ns / 1ps

module fca_ctrl #(
  parameter int NUM_BLOCKS  = fca_pkg::NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = fca_pkg::BLOCK_BYTES_DEF,
  parameter int ADDR_W      = $clog2(NUM_BLOCKS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Request side.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fca_pkg::fca_in_t              in_data,
  // Data start register write.
  input  logic                          cfg_we,
  input  fca_pkg::fca_ds_t              cfg_data,
  // Result side.
  output logic                          res_valid,
  input  logic                          res_ready,
  output fca_pkg::fca_out_t             res_data,
  // Table port.
  output logic                          ram_we,
  output logic [ADDR_W-1:0]             ram_waddr,
  output logic [fca_pkg::ENTRY_W-1:0]   ram_wdata,
  output logic                          ram_re,
  output logic [ADDR_W-1:0]             ram_raddr,
  input  logic [fca_pkg::ENTRY_W-1:0]   ram_rdata
);
  import fca_pkg::*;

  localparam int CMP_W  = ENTRY_W + 1;
  localparam int ACC_W  = LEN_W + 1;
  localparam int SCAN_W = ((ADDR_W > DS_W) ? ADDR_W : DS_W) + 1;
  localparam int LIMIT  = (NUM_BLOCKS < int'(FAT_END)) ? NUM_BLOCKS : int'(FAT_END);

  fca_state_t          state_r, state_nxt;
  fca_action_t         act_r, act_nxt;
  fca_status_t         status_r, status_nxt;
  logic [DS_W-1:0]     ds_r;
  logic [ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [ADDR_W-1:0]   cur_r, cur_nxt;
  logic [ADDR_W-1:0]   fv_r, fv_nxt;
  logic [ENTRY_W-1:0]  v_r, v_nxt;
  logic [IDX_OUT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]    changed_r, changed_nxt;
  logic [SCAN_W-1:0]   scan_addr_r, scan_addr_nxt;
  logic                pend_r, pend_nxt;
  logic [ADDR_W-1:0]   paddr_r, paddr_nxt;

  logic                v_link;
  logic                more;
  logic [ADDR_W-1:0]   v_addr;
  logic [SCAN_W-1:0]   scan_start;

  // An entry is a link if it is neither free nor the end mark and points
  // inside the table.
  function automatic logic is_link(input logic [ENTRY_W-1:0] v);
    return (v != FAT_FREE) && (v != FAT_END) && (CMP_W'(v) < CMP_W'(NUM_BLOCKS));
  endfunction

  assign v_link     = is_link(v_r);
  assign v_addr     = v_r[ADDR_W-1:0];
  assign more       = (acc_r <= ACC_W'(len_r));
  assign scan_start = (ds_r == '0) ? SCAN_W'(1) : SCAN_W'(ds_r);

  assign res_data.status         = status_r;
  assign res_data.block_index    = idx_r;
  assign res_data.blocks_changed = changed_r;

  // Data start register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ds_r <= DS_RESET;
    end else if (cfg_we) begin
      ds_r <= cfg_data;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      pend_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      pend_r     <= pend_nxt;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    status_r    <= status_nxt;
    len_r       <= len_nxt;
    acc_r       <= acc_nxt;
    cur_r       <= cur_nxt;
    fv_r        <= fv_nxt;
    v_r         <= v_nxt;
    idx_r       <= idx_nxt;
    changed_r   <= changed_nxt;
    scan_addr_r <= scan_addr_nxt;
    paddr_r     <= paddr_nxt;
  end

  // Next state, table accesses and result bookkeeping.
  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    status_nxt    = status_r;
    clr_addr_nxt  = clr_addr_r;
    len_nxt       = len_r;
    acc_nxt       = acc_r;
    cur_nxt       = cur_r;
    fv_nxt        = fv_r;
    v_nxt         = v_r;
    idx_nxt       = idx_r;
    changed_nxt   = changed_r;
    scan_addr_nxt = scan_addr_r;
    pend_nxt      = pend_r;
    paddr_nxt     = paddr_r;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = cur_r;
    ram_wdata     = FAT_FREE;
    ram_re        = 1'b0;
    ram_raddr     = cur_r;

    unique case (state_r)
      // Clearing pass after reset: every entry becomes free.
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        if (clr_addr_r == ADDR_W'(NUM_BLOCKS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end

      // Take a request and start its walk or scan.
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          act_nxt     = fca_action_t'(in_data.action);
          len_nxt     = (in_data.byte_length > MAX_FILE_BYTES) ?
                        MAX_FILE_BYTES : in_data.byte_length;
          acc_nxt     = ACC_W'(BLOCK_BYTES);
          changed_nxt = '0;
          status_nxt  = STAT_OK;
          idx_nxt     = '0;
          if (fca_action_t'(in_data.action) == ACT_ALLOC) begin
            scan_addr_nxt = scan_start;
            pend_nxt      = 1'b0;
            state_nxt     = ST_SCAN;
          end else if (CMP_W'(in_data.head_block) >= CMP_W'(NUM_BLOCKS)) begin
            status_nxt = STAT_CORRUPT;
            idx_nxt    = in_data.head_block;
            state_nxt  = ST_DONE;
          end else begin
            cur_nxt   = ADDR_W'(in_data.head_block);
            ram_re    = 1'b1;
            ram_raddr = ADDR_W'(in_data.head_block);
            state_nxt = ST_HEAD;
          end
        end
      end

      // Head entry arrives: a free head is a corrupt chain.
      ST_HEAD: begin
        if (ram_rdata == FAT_FREE) begin
          status_nxt = STAT_CORRUPT;
          idx_nxt    = IDX_OUT_W'(cur_r);
          state_nxt  = ST_DONE;
        end else begin
          v_nxt = ram_rdata;
          case (act_r)
            ACT_FREE:   state_nxt = ST_FREE;
            ACT_EXTEND: state_nxt = ST_EXT_CHK;
            default:    state_nxt = ST_TRN_CHK;
          endcase
        end
      end

      // First-fit scan, one read issued per cycle.
      ST_SCAN: begin
        if (pend_r && (ram_rdata == FAT_FREE)) begin
          pend_nxt = 1'b0;
          ram_we   = 1'b1;
          if (act_r == ACT_ALLOC) begin
            ram_waddr   = paddr_r;
            ram_wdata   = FAT_END;
            idx_nxt     = IDX_OUT_W'(paddr_r);
            changed_nxt = CNT_W'(1);
            state_nxt   = ST_DONE;
          end else begin
            ram_waddr = cur_r;
            ram_wdata = ENTRY_W'(paddr_r);
            cur_nxt   = paddr_r;
            state_nxt = ST_EXT_END;
          end
        end else if (scan_addr_r < SCAN_W'(LIMIT)) begin
          ram_re        = 1'b1;
          ram_raddr     = scan_addr_r[ADDR_W-1:0];
          pend_nxt      = 1'b1;
          paddr_nxt     = scan_addr_r[ADDR_W-1:0];
          scan_addr_nxt = scan_addr_r + 1'b1;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          status_nxt = STAT_NO_FREE;
          idx_nxt    = (act_r == ACT_ALLOC) ? '0 : IDX_OUT_W'(cur_r);
          state_nxt  = ST_DONE;
        end
      end

      // Free: release the current block and follow its link.
      ST_FREE: begin
        if (v_r == FAT_END) begin
          ram_we      = 1'b1;
          changed_nxt = changed_r + 1'b1;
          idx_nxt     = IDX_OUT_W'(cur_r);
          state_nxt   = ST_DONE;
        end else if (!v_link) begin
          status_nxt = STAT_CORRUPT;
          idx_nxt    = IDX_OUT_W'(cur_r);
          state_nxt  = ST_DONE;
        end else begin
          ram_we      = 1'b1;
          changed_nxt = changed_r + 1'b1;
          cur_nxt     = v_addr;
          ram_re      = 1'b1;
          ram_raddr   = v_addr;
          state_nxt   = ST_FREE_RD;
        end
      end

      ST_FREE_RD: begin
        v_nxt     = ram_rdata;
        state_nxt = ST_FREE;
      end

      // Extend: walk existing links, append a free block at the end.
      ST_EXT_CHK: begin
        if (!more) begin
          idx_nxt   = IDX_OUT_W'(cur_r);
          state_nxt = ST_DONE;
        end else begin
          acc_nxt = acc_r + ACC_W'(BLOCK_BYTES);
          if (v_r == FAT_END) begin
            scan_addr_nxt = scan_start;
            pend_nxt      = 1'b0;
            state_nxt     = ST_SCAN;
          end else if (v_link) begin
            ram_re    = 1'b1;
            ram_raddr = v_addr;
            state_nxt = ST_EXT_RD;
          end else begin
            status_nxt = STAT_CORRUPT;
            idx_nxt    = IDX_OUT_W'(cur_r);
            state_nxt  = ST_DONE;
          end
        end
      end

      ST_EXT_RD: begin
        if (ram_rdata == FAT_FREE) begin
          status_nxt = STAT_CORRUPT;
          idx_nxt    = IDX_OUT_W'(cur_r);
          state_nxt  = ST_DONE;
        end else begin
          cur_nxt   = v_addr;
          v_nxt     = ram_rdata;
          state_nxt = ST_EXT_CHK;
        end
      end

      // The new block becomes the end of the chain.
      ST_EXT_END: begin
        ram_we      = 1'b1;
        ram_wdata   = FAT_END;
        changed_nxt = changed_r + 1'b1;
        v_nxt       = FAT_END;
        state_nxt   = ST_EXT_CHK;
      end

      // Truncate: walk to the last block that is kept.
      ST_TRN_CHK: begin
        if (!more) begin
          state_nxt = ST_TRN_CUT;
        end else begin
          acc_nxt = acc_r + ACC_W'(BLOCK_BYTES);
          if (v_r == FAT_END) begin
            idx_nxt   = IDX_OUT_W'(cur_r);
            state_nxt = ST_DONE;
          end else if (!v_link) begin
            status_nxt = STAT_CORRUPT;
            idx_nxt    = IDX_OUT_W'(cur_r);
            state_nxt  = ST_DONE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = v_addr;
            state_nxt = ST_TRN_RD;
          end
        end
      end

      ST_TRN_RD: begin
        if (ram_rdata == FAT_FREE) begin
          status_nxt = STAT_CORRUPT;
          idx_nxt    = IDX_OUT_W'(cur_r);
          state_nxt  = ST_DONE;
        end else begin
          cur_nxt   = v_addr;
          v_nxt     = ram_rdata;
          state_nxt = ST_TRN_CHK;
        end
      end

      // The kept length is reached: cut the chain after the current block.
      ST_TRN_CUT: begin
        idx_nxt = IDX_OUT_W'(cur_r);
        if (v_r == FAT_END) begin
          state_nxt = ST_DONE;
        end else if (!v_link) begin
          status_nxt = STAT_CORRUPT;
          state_nxt  = ST_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = v_addr;
          state_nxt = ST_TRN_CUT_RD;
        end
      end

      // Mark the new end. If the new end links to itself, the tail entry now
      // reads as the end mark.
      ST_TRN_CUT_RD: begin
        if (ram_rdata == FAT_FREE) begin
          status_nxt = STAT_CORRUPT;
          state_nxt  = ST_DONE;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = FAT_END;
          fv_nxt    = v_addr;
          v_nxt     = (v_addr == cur_r) ? FAT_END : ram_rdata;
          state_nxt = ST_TRN_FREE;
        end
      end

      // Free the tail one block at a time; v_r holds the freed entry's link.
      ST_TRN_FREE: begin
        ram_we      = 1'b1;
        ram_waddr   = fv_r;
        changed_nxt = changed_r + 1'b1;
        if (v_r == FAT_END) begin
          state_nxt = ST_DONE;
        end else if (!v_link) begin
          status_nxt = STAT_CORRUPT;
          state_nxt  = ST_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = v_addr;
          fv_nxt    = v_addr;
          state_nxt = ST_TRN_FREE_RD;
        end
      end

      ST_TRN_FREE_RD: begin
        if (ram_rdata == FAT_FREE) begin
          status_nxt = STAT_CORRUPT;
          state_nxt  = ST_DONE;
        end else begin
          v_nxt     = ram_rdata;
          state_nxt = ST_TRN_FREE;
        end
      end

      // Hand the result to the output register.
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/fca_checker.sv =====
// Port-level checks of the FAT chain allocator, bound to the top level.
// Depends on fca_pkg and the macros in fat_chain_allocator_unit_assert.svh.
`timescale 1ns / 1ps
`include "fat_chain_allocator_unit_assert.svh"

module fca_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input fca_pkg::fca_out_t out_data
);
  import fca_pkg::*;

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  // Reset starts the clearing pass, so no request is taken right after it.
  `FCA_ASSERT_NEXT_RST(a_reset_blocks_input, clk, !rst_n, !in_ready)

  // The block does not take a new request in the cycle after it accepts one.
  `FCA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, !in_ready)

  // No result can appear in the cycle right after its request.
  `FCA_ASSERT_NEXT(a_no_instant_result, clk, rst_n, in_acc && !out_valid, !out_valid)

  // A stalled result beat holds.
  `FCA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                   out_valid && $stable(out_data))

endmodule

bind fat_chain_allocator_unit fca_checker u_fca_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

// ===== dv/tb_fat_chain_allocator_unit.sv =====
// Self-checking testbench for fat_chain_allocator_unit: it keeps its own copy of the
// allocation table and checks every result beat against that copy.
// Depends on fca_pkg, the fca_chan_if interface and the allocator top level.
`timescale 1ns / 1ps

module tb_fat_chain_allocator_unit;
  import fca_pkg::*;

  localparam int NUM_BLOCKS     = NUM_BLOCKS_DEF;
  localparam int BLOCK_BYTES    = BLOCK_BYTES_DEF;
  localparam int SCAN_END       = (NUM_BLOCKS < int'(FAT_END)) ? NUM_BLOCKS : int'(FAT_END);
  localparam int LEN_MAX        = (1 << LEN_W) - 1;
  localparam int SHORT_LEN      = 12 * BLOCK_BYTES - 1;
  localparam int RESET_CYCLES   = 9;
  localparam int LONG_HOLD      = 400;
  localparam int TAIL_CYCLES    = 64;
  localparam int WATCHDOG_LIMIT = 50000;

  logic clk;
  logic rst_n;

  fca_chan_if #(.payload_t(fca_in_t))  in_if ();
  fca_chan_if #(.payload_t(fca_out_t)) out_if ();
  fca_chan_if #(.payload_t(fca_ds_t))  cfg_if ();

  fat_chain_allocator_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Shadow copy of the table and the data start register.
  logic [ENTRY_W-1:0] fat_model [NUM_BLOCKS];
  fca_ds_t            data_start_model;
  int                 used_blocks;

  fca_out_t expected_results [$];
  int       chain_heads [$];
  int       mismatch_count;
  int       burst_left;
  int       hold_requests;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit is_link(logic [ENTRY_W-1:0] v);
    return v != FAT_FREE && v != FAT_END && int'(v) < NUM_BLOCKS;
  endfunction

  // First-fit search from the data start; zero means nothing is free.
  function automatic int first_free_block();
    int j;
    j = (data_start_model == '0) ? 1 : int'(data_start_model);
    while (j < SCAN_END) begin
      if (fat_model[j] == FAT_FREE) return j;
      j++;
    end
    return 0;
  endfunction

  // Applies one request to the shadow table and returns the result it must produce.
  function automatic fca_out_t predict_chain_update(fca_in_t req);
    fca_out_t           res;
    fca_action_t        act;
    fca_status_t        st;
    logic [ENTRY_W-1:0] v;
    logic [ENTRY_W-1:0] w;
    int                 head, len, target, cur, cnt, j, idx, changed;
    act     = fca_action_t'(req.action);
    head    = int'(req.head_block);
    len     = int'(req.byte_length);
    st      = STAT_OK;
    idx     = 0;
    changed = 0;
    if (len > int'(MAX_FILE_BYTES)) len = int'(MAX_FILE_BYTES);
    target = len / BLOCK_BYTES + 1;

    if (act == ACT_ALLOC) begin
      j = first_free_block();
      if (j == 0) begin
        st = STAT_NO_FREE;
      end else begin
        fat_model[j] = FAT_END;
        idx          = j;
        changed      = 1;
      end
    end else if (head >= NUM_BLOCKS || fat_model[head] == FAT_FREE) begin
      st  = STAT_CORRUPT;
      idx = head;
    end else if (act == ACT_FREE) begin
      // Release every block from the head until the end mark or a bad link.
      cur = head;
      forever begin
        v = fat_model[cur];
        if (v == FAT_END) begin
          fat_model[cur] = FAT_FREE;
          changed++;
          break;
        end
        if (!is_link(v)) begin
          st = STAT_CORRUPT;
          break;
        end
        fat_model[cur] = FAT_FREE;
        changed++;
        cur = int'(v);
      end
      idx = cur;
    end else if (act == ACT_EXTEND) begin
      // Follow existing links, then append free blocks at the end mark.
      cur = head;
      for (cnt = 1; cnt < target; cnt++) begin
        v = fat_model[cur];
        if (v == FAT_END) begin
          j = first_free_block();
          if (j == 0) begin
            st = STAT_NO_FREE;
            break;
          end
          fat_model[cur] = ENTRY_W'(j);
          fat_model[j]   = FAT_END;
          changed++;
          cur = j;
        end else if (is_link(v) && fat_model[int'(v)] != FAT_FREE) begin
          cur = int'(v);
        end else begin
          st = STAT_CORRUPT;
          break;
        end
      end
      idx = cur;
    end else begin
      // Walk to the last kept block, then cut the chain and free the tail.
      cur = head;
      for (cnt = 1; cnt < target; cnt++) begin
        v = fat_model[cur];
        if (v == FAT_END) break;
        if (!is_link(v) || fat_model[int'(v)] == FAT_FREE) begin
          st = STAT_CORRUPT;
          break;
        end
        cur = int'(v);
      end
      idx = cur;
      if (st == STAT_OK) begin
        v = fat_model[cur];
        if (v != FAT_END) begin
          if (!is_link(v) || fat_model[int'(v)] == FAT_FREE) begin
            st = STAT_CORRUPT;
          end else begin
            fat_model[cur] = FAT_END;
            forever begin
              w = fat_model[int'(v)];
              fat_model[int'(v)] = FAT_FREE;
              changed++;
              if (w == FAT_END) break;
              if (!is_link(w) || fat_model[int'(w)] == FAT_FREE) begin
                st = STAT_CORRUPT;
                break;
              end
              v = w;
            end
          end
        end
      end
    end

    if (act == ACT_ALLOC || act == ACT_EXTEND) used_blocks += changed;
    else used_blocks -= changed;

    res.status         = st;
    res.block_index    = IDX_OUT_W'(idx);
    res.blocks_changed = CNT_W'(changed);
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Sends one request beat in bursts with random gaps, then records its expected result.
  task automatic send_request(fca_action_t act, int head, int len);
    fca_in_t  req;
    fca_out_t res;
    int       gap;
    req.action      = act;
    req.head_block  = DS_W'(head);
    req.byte_length = LEN_W'(len);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.data  <= req;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    res = predict_chain_update(req);
    expected_results.push_back(res);
    if (act == ACT_ALLOC && res.status == STAT_OK) chain_heads.push_back(int'(res.block_index));
  endtask

  // Stops offering requests until every outstanding result has arrived.
  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_data_start(fca_ds_t value);
    wait_for_drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    data_start_model = value;
  endtask

  // Mostly well-formed chain operations with random content, plus requests aimed
  // inside chains and at arbitrary blocks.
  task automatic run_mixed_requests(int count);
    fca_action_t act;
    int          roll, k, head, len, steps;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      // Keep the table sparse so first-fit scans stay short.
      if (used_blocks > 300 && roll < 45) roll = 70;
      if (chain_heads.size() == 0 && roll < 92) roll = 0;
      act  = ACT_ALLOC;
      head = $urandom_range(0, NUM_BLOCKS - 1);
      len  = $urandom_range(0, LEN_MAX);
      k    = (chain_heads.size() != 0) ? $urandom_range(0, chain_heads.size() - 1) : 0;
      if (roll >= 25 && roll < 92) head = chain_heads[k];
      if (roll >= 92) begin
        act = fca_action_t'($urandom_range(0, 3));
        if (act == ACT_EXTEND) len = $urandom_range(0, SHORT_LEN);
      end else if (roll >= 84) begin
        // Land on a block inside the chain, which leaves dangling links behind.
        act   = fca_action_t'($urandom_range(1, 3));
        steps = $urandom_range(1, 6);
        while (steps > 0 && is_link(fat_model[head])) begin
          head = int'(fat_model[head]);
          steps--;
        end
        len = $urandom_range(0, SHORT_LEN);
      end else if (roll >= 62) begin
        act = ACT_FREE;
        chain_heads.delete(k);
      end else if (roll >= 45) begin
        act = ACT_TRUNC;
        if ($urandom_range(0, 3) != 0) len = $urandom_range(0, 8 * BLOCK_BYTES - 1);
      end else if (roll >= 25) begin
        act = ACT_EXTEND;
        len = $urandom_range(0, SHORT_LEN);
      end
      send_request(act, head, len);
    end
  endtask

  // Allocate, grow, shrink and release one chain, with length saturation.
  task automatic test_basic_chain_ops();
    int a;
    send_request(ACT_ALLOC, 0, 0);
    a = chain_heads[$];
    send_request(ACT_EXTEND, a, 2 * BLOCK_BYTES + 5);
    send_request(ACT_EXTEND, a, BLOCK_BYTES);
    send_request(ACT_TRUNC, a, 2 * BLOCK_BYTES - 1);
    send_request(ACT_TRUNC, a, LEN_MAX);
    send_request(ACT_FREE, a, 0);
  endtask

  // Heads that are free, and chains whose links point at freed blocks.
  task automatic test_bad_head_and_broken_link();
    int b, c, d, e;
    send_request(ACT_FREE, NUM_BLOCKS - 1, 0);
    send_request(ACT_EXTEND, 0, BLOCK_BYTES);
    send_request(ACT_ALLOC, 0, 0);
    b = chain_heads[$];
    send_request(ACT_EXTEND, b, BLOCK_BYTES);
    c = int'(fat_model[b]);
    send_request(ACT_FREE, c, 0);
    send_request(ACT_FREE, b, 0);
    send_request(ACT_ALLOC, 0, 0);
    d = chain_heads[$];
    send_request(ACT_EXTEND, d, 2 * BLOCK_BYTES);
    e = int'(fat_model[d]);
    send_request(ACT_FREE, e, 0);
    send_request(ACT_TRUNC, d, 3 * BLOCK_BYTES);
    send_request(ACT_FREE, d, 0);
  endtask

  // Zero data start, and a data start so high that the table runs out of free blocks.
  task automatic test_data_start_extremes();
    int h;
    write_data_start('0);
    send_request(ACT_ALLOC, 0, 0);
    send_request(ACT_FREE, chain_heads[$], 0);
    write_data_start(fca_ds_t'(NUM_BLOCKS - 2));
    send_request(ACT_ALLOC, 0, 0);
    h = chain_heads[$];
    send_request(ACT_EXTEND, h, int'(MAX_FILE_BYTES));
    send_request(ACT_ALLOC, 0, 0);
    send_request(ACT_TRUNC, h, 0);
    send_request(ACT_FREE, h, 0);
    write_data_start(fca_ds_t'(NUM_BLOCKS - 1));
    send_request(ACT_ALLOC, 0, 0);
    send_request(ACT_ALLOC, 0, 0);
    send_request(ACT_FREE, NUM_BLOCKS - 1, 0);
  endtask

  // Long result stall while requests keep coming, then a full drain before more.
  task automatic test_output_backpressure();
    write_data_start(DS_RESET);
    hold_requests <= hold_requests + 1;
    run_mixed_requests(20);
    wait_for_drain();
    run_mixed_requests(20);
  endtask

  // Random traffic over several data start settings.
  task automatic test_random_traffic();
    fca_ds_t starts [8];
    starts = '{fca_ds_t'(1), DS_RESET, fca_ds_t'(0), fca_ds_t'(NUM_BLOCKS - 1),
               fca_ds_t'(200), fca_ds_t'($urandom_range(1, 1000)), fca_ds_t'(4096),
               fca_ds_t'(1)};
    foreach (starts[i]) begin
      write_data_start(starts[i]);
      run_mixed_requests(135);
    end
  endtask

  // Result checker and receiver stall pattern.
  initial begin : result_checker
    fca_out_t    want;
    fca_out_t    got;
    logic [15:0] stall_pat;
    int          hold_left, hold_served, pat_age;
    out_if.ready <= 1'b0;
    stall_pat   = '1;
    hold_left   = 0;
    hold_served = 0;
    pat_age     = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status=%0d block=%0d changed=%0d",
                                    got.status, got.block_index, got.blocks_changed));
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.block_index !== want.block_index ||
              got.blocks_changed !== want.blocks_changed) begin
            report_mismatch($sformatf(
              "expected status=%0d block=%0d changed=%0d, got status=%0d block=%0d changed=%0d",
              want.status, want.block_index, want.blocks_changed,
              got.status, got.block_index, got.blocks_changed));
          end
        end
      end
      // A new long hold request from the test sequence.
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = LONG_HOLD;
      end
      // Swap the stall pattern now and then; all ones gives stall-free stretches.
      pat_age++;
      if (pat_age >= 96) begin
        pat_age = 0;
        case ($urandom_range(0, 3))
          0: stall_pat = '1;
          1: stall_pat = 16'($urandom);
          2: stall_pat = 16'($urandom | $urandom);
          default: stall_pat = 16'($urandom & $urandom);
        endcase
        stall_pat[0] = 1'b1;
      end
      stall_pat = {stall_pat[14:0], stall_pat[15]};
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= stall_pat[0];
      end
    end
  end

  // Ends the run when no beat moves on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Test sequence.
  initial begin : test_sequence
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    foreach (fat_model[i]) fat_model[i] = FAT_FREE;
    data_start_model = DS_RESET;
    used_blocks      = 0;
    mismatch_count   = 0;
    burst_left       = 0;
    hold_requests    = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_chain_ops();
    test_bad_head_and_broken_link();
    test_data_start_extremes();
    test_output_backpressure();
    test_random_traffic();

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatch_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
